>>> rtl/bmprle_pkg.sv
// Shared types, codes and constants of the BMP RLE line decoder.
package bmprle_pkg;

    // Widths of the datapath.
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COL_W      = 13;
    localparam int unsigned START_W    = 12;
    localparam int unsigned MAX_RECORDS = 3;
    localparam int unsigned REC_CNT_W  = 2;

    // Largest line the decoder accepts; the configured width is clamped to it.
    localparam int unsigned MAX_LINE_PIXELS = 4096;
    localparam int unsigned LIMIT_PIXELS    = (MAX_LINE_PIXELS < 4096) ? MAX_LINE_PIXELS : 4096;
    localparam logic [COL_W-1:0] LINE_LIMIT = COL_W'(LIMIT_PIXELS);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 1'b1;

    // Reset value of the line width register.
    localparam logic [COL_W-1:0] LINE_WIDTH_RESET = 13'd640;

    // Escape codes that follow a zero first byte.
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_DX     = 3'd2,
        PH_DY     = 3'd3,
        PH_ABS    = 3'd4,
        PH_PAD    = 3'd5
    } t_phase;

    // Kind of an emitted record.
    typedef enum logic [2:0] {
        KIND_RUN   = 3'd0,
        KIND_FILL  = 3'd1,
        KIND_EOL   = 3'd2,
        KIND_BLANK = 3'd3,
        KIND_EOB   = 3'd4,
        KIND_ERROR = 3'd5
    } t_kind;

    // One run record.
    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   first_index;
        logic [BYTE_W-1:0]   second_index;
        logic [COL_W-1:0]    run_count;
        logic [START_W-1:0]  start_column;
    } t_record;

    // All records caused by one item, with their number.
    typedef struct packed {
        logic [REC_CNT_W-1:0]              count;
        t_record [MAX_RECORDS-1:0]         recs;
    } t_batch;

    // Builds a record from its fields.
    function automatic t_record make_rec(t_kind kind, logic [BYTE_W-1:0] a,
                                         logic [BYTE_W-1:0] b, logic [COL_W-1:0] cnt,
                                         logic [COL_W-1:0] col);
        t_record r;
        r.kind         = kind;
        r.first_index  = a;
        r.second_index = b;
        r.run_count    = cnt;
        r.start_column = col[START_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/bmprle_decode.sv
// Parser of the RLE byte stream: holds the parse state and forms the records of one byte.
module bmprle_decode
    import bmprle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [BYTE_W-1:0]    i_byte,
    input  logic                 i_four_bit_mode,
    input  logic [COL_W-1:0]     i_width,
    output t_batch               o_batch
);

    t_phase              r_phase,  n_phase;
    logic [BYTE_W-1:0]   r_held,   n_held;
    logic [COL_W-1:0]    r_column, n_column;
    logic [BYTE_W-1:0]   r_left,   n_left;
    logic                r_pad,    n_pad;
    logic [BYTE_W-1:0]   r_dx,     n_dx;
    logic                r_err,    n_err;

    logic [COL_W:0]      s_sum_held;
    logic [COL_W:0]      s_sum_byte;
    logic [COL_W:0]      s_target;
    logic [COL_W:0]      s_width_x;
    logic                s_has_rest;
    logic [COL_W-1:0]    s_rest;
    logic [1:0]          s_abs_cnt;
    logic [BYTE_W-1:0]   s_abs_left;
    logic [BYTE_W:0]     s_byte_plus1;
    logic [BYTE_W-1:0]   s_hi;
    logic [BYTE_W-1:0]   s_lo;
    logic                s_fail;

    // Shared sums, checks and nibble split.
    always_comb begin
        s_width_x    = {1'b0, i_width};
        s_sum_held   = {1'b0, r_column} + {{(COL_W+1-BYTE_W){1'b0}}, r_held};
        s_sum_byte   = {1'b0, r_column} + {{(COL_W+1-BYTE_W){1'b0}}, i_byte};
        s_target     = {1'b0, r_column} + {{(COL_W+1-BYTE_W){1'b0}}, r_dx};
        s_has_rest   = (r_column < i_width);
        s_rest       = i_width - r_column;
        s_byte_plus1 = {1'b0, i_byte} + 9'd1;
        if (i_four_bit_mode) begin
            s_hi = {4'd0, i_byte[7:4]};
            s_lo = {4'd0, i_byte[3:0]};
        end else begin
            s_hi = i_byte;
            s_lo = i_byte;
        end
        // An absolute byte carries two pixels in 4-bit mode, never more than are left.
        s_abs_cnt = (i_four_bit_mode && (r_left >= 8'd2)) ? 2'd2 : 2'd1;
        if ({6'd0, s_abs_cnt} > r_left) begin
            s_abs_cnt = r_left[1:0];
        end
        s_abs_left = r_left - {6'd0, s_abs_cnt};
    end

    // Overflow of the line, or an error already latched.
    always_comb begin
        s_fail = r_err;
        if (r_phase == PH_SECOND) begin
            if (r_held != '0) begin
                s_fail = s_fail || (s_sum_held > s_width_x);
            end else if ((i_byte != ESC_EOL) && (i_byte != ESC_EOB) &&
                         (i_byte != ESC_DELTA)) begin
                s_fail = s_fail || (s_sum_byte > s_width_x);
            end
        end else if (r_phase == PH_DY) begin
            s_fail = s_fail || (s_target > s_width_x);
        end
    end

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (s_fail) begin
            n_phase = PH_FIRST;
        end else begin
            unique case (r_phase)
                PH_FIRST:  n_phase = PH_SECOND;
                PH_SECOND: begin
                    if (r_held != '0) begin
                        n_phase = PH_FIRST;
                    end else begin
                        unique case (i_byte) inside
                            ESC_EOL, ESC_EOB: n_phase = PH_FIRST;
                            ESC_DELTA:        n_phase = PH_DX;
                            default:          n_phase = PH_ABS;
                        endcase
                    end
                end
                PH_DX:     n_phase = PH_DY;
                PH_DY:     n_phase = PH_FIRST;
                PH_ABS: begin
                    if (s_abs_left == '0) begin
                        n_phase = r_pad ? PH_PAD : PH_FIRST;
                    end
                end
                PH_PAD:    n_phase = PH_FIRST;
                default:   n_phase = PH_FIRST;
            endcase
        end
    end

    // Next values of the column, held bytes and absolute-run counters.
    always_comb begin
        n_held   = r_held;
        n_column = r_column;
        n_left   = r_left;
        n_pad    = r_pad;
        n_dx     = r_dx;
        n_err    = r_err;
        if (s_fail) begin
            n_err = 1'b1;
        end else begin
            case (r_phase)
                PH_FIRST: n_held = i_byte;
                PH_SECOND: begin
                    if (r_held != '0) begin
                        n_column = s_sum_held[COL_W-1:0];
                    end else if ((i_byte == ESC_EOL) || (i_byte == ESC_EOB)) begin
                        n_column = '0;
                    end else if (i_byte != ESC_DELTA) begin
                        n_left = i_byte;
                        n_pad  = i_four_bit_mode ? s_byte_plus1[1] : i_byte[0];
                    end
                end
                PH_DX: n_dx = i_byte;
                PH_DY: n_column = s_target[COL_W-1:0];
                PH_ABS: begin
                    n_column = r_column + {{(COL_W-2){1'b0}}, s_abs_cnt};
                    n_left   = s_abs_left;
                    if (s_abs_left == '0) begin
                        n_pad = 1'b0;
                    end
                end
                PH_PAD: n_pad = 1'b0;
                default: ;
            endcase
        end
    end

    // Records caused by the current byte.
    always_comb begin
        logic [REC_CNT_W-1:0] v_k;
        v_k     = '0;
        o_batch = '0;
        if (s_fail) begin
            o_batch.recs[0] = make_rec(KIND_ERROR, '0, '0, '0, '0);
            v_k = 2'd1;
        end else begin
            unique case (r_phase)
                PH_SECOND: begin
                    if (r_held != '0) begin
                        o_batch.recs[0] = make_rec(KIND_RUN, s_hi, s_lo,
                                                   {5'd0, r_held}, r_column);
                        v_k = 2'd1;
                    end else if ((i_byte == ESC_EOL) || (i_byte == ESC_EOB)) begin
                        if (s_has_rest) begin
                            o_batch.recs[v_k] = make_rec(KIND_FILL, '0, '0, s_rest, r_column);
                            v_k = v_k + 2'd1;
                        end
                        o_batch.recs[v_k] = make_rec((i_byte == ESC_EOL) ? KIND_EOL : KIND_EOB,
                                                     '0, '0, '0, '0);
                        v_k = v_k + 2'd1;
                    end
                end
                PH_DY: begin
                    if (i_byte == '0) begin
                        if (r_dx != '0) begin
                            o_batch.recs[0] = make_rec(KIND_FILL, '0, '0, {5'd0, r_dx}, r_column);
                            v_k = 2'd1;
                        end
                    end else begin
                        if (s_has_rest) begin
                            o_batch.recs[v_k] = make_rec(KIND_FILL, '0, '0, s_rest, r_column);
                            v_k = v_k + 2'd1;
                        end
                        o_batch.recs[v_k] = make_rec(KIND_BLANK, '0, '0,
                                                     {5'd0, i_byte - 8'd1}, '0);
                        v_k = v_k + 2'd1;
                        if (s_target != '0) begin
                            o_batch.recs[v_k] = make_rec(KIND_FILL, '0, '0,
                                                         s_target[COL_W-1:0], '0);
                            v_k = v_k + 2'd1;
                        end
                    end
                end
                PH_ABS: begin
                    o_batch.recs[0] = make_rec(KIND_RUN, s_hi, s_lo,
                                               {11'd0, s_abs_cnt}, r_column);
                    v_k = 2'd1;
                end
                default: ;
            endcase
        end
        o_batch.count = v_k;
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_held   <= '0;
            r_column <= '0;
            r_left   <= '0;
            r_pad    <= 1'b0;
            r_dx     <= '0;
            r_err    <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_column <= n_column;
            r_left   <= n_left;
            r_pad    <= n_pad;
            r_dx     <= n_dx;
            r_err    <= n_err;
        end
    end

`ifndef SYNTHESIS
    // Once latched, an error gives exactly one error record per byte.
    a_error_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && i_accept) |-> (o_batch.count == 2'd1 &&
                                 o_batch.recs[0].kind == KIND_ERROR))
        else $error("latched error did not give a single error record");

    // Inside an absolute run at least one pixel is always still due.
    a_abs_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ABS) |-> (r_left != '0))
        else $error("absolute run phase with no pixels left");

    // The column never passes the longest line.
    a_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column <= LINE_LIMIT)
        else $error("column beyond the longest line");
`endif

endmodule

>>> rtl/bmprle_outq.sv
// Result buffer: holds one byte's records, hands one out per unstalled cycle.
module bmprle_outq
    import bmprle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    output logic                 o_item_stall,
    output logic                 o_accept,
    input  t_batch               i_batch,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_record              o_rec,
    output logic                 o_last
);

    t_record [MAX_RECORDS-1:0]   r_recs;
    logic [REC_CNT_W-1:0]        r_left;
    logic                        s_take;

    // A new item enters when the buffer is empty or its last record leaves now.
    always_comb begin
        o_valid      = (r_left != '0);
        s_take       = o_valid && !i_stall;
        o_item_stall = !((r_left == '0) || ((r_left == 2'd1) && !i_stall));
        o_accept     = i_item_valid && !o_item_stall;
        o_rec        = r_recs[0];
        o_last       = (r_left == 2'd1);
    end

    // Record count, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (o_accept) begin
            r_left <= i_batch.count;
        end else if (s_take) begin
            r_left <= r_left - 2'd1;
        end
    end

    // Record payload: load a fresh batch or shift the next record to the front.
    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_recs <= i_batch.recs;
        end else if (s_take) begin
            r_recs[0] <= r_recs[1];
            r_recs[1] <= r_recs[2];
        end
    end

`ifndef SYNTHESIS
    // A loaded batch shows exactly the number of records formed for it.
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_accept |=> (r_left == $past(i_batch.count)))
        else $error("record count lost on load");

    // When the final record leaves and nothing enters, the output goes quiet.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && (r_left == 2'd1) && !o_accept) |=> !o_valid)
        else $error("record repeated after the last one left");

    // A stalled record stays on the output unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rec) && $stable(o_last)))
        else $error("stalled record changed");
`endif

endmodule

>>> rtl/bmp_rle_line_decoder_unit.sv
// BMP RLE8 / RLE4 line decoder that turns a compressed byte stream into run records.
// One compressed byte enters per cycle while o_stall is low, and its records come
// out of a single record register, one per cycle while i_stall is low, with
// last_of_run marking the final record of each byte. A byte that gives no
// record or one record holds the input only while the receiver stalls, so runs
// of pairs and absolute data stream at one byte per cycle. End of line and end
// of bitmap give up to two records and a delta that changes line up to three;
// such a byte holds the input until its last record leaves. The next byte is taken in
// the same cycle as the last record of the previous one. Configuration writes are
// accepted in every cycle and act at once; write them only while the decoder is idle.
module bmp_rle_line_decoder_unit
    import bmprle_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Byte input.
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [BYTE_W-1:0]      i_stream_byte,
    // Record output.
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [2:0]             o_record_kind,
    output logic [BYTE_W-1:0]      o_first_index,
    output logic [BYTE_W-1:0]      o_second_index,
    output logic [COL_W-1:0]       o_run_count,
    output logic [START_W-1:0]     o_start_column,
    output logic                   o_last_of_run,
    // Configuration writes.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COL_W-1:0]       i_cfg_data
);

    logic                r_four_bit_mode;
    logic [COL_W-1:0]    r_line_width;
    logic [COL_W-1:0]    s_width;
    logic                s_accept;
    t_batch              s_batch;
    t_record             s_rec;

    // Configuration registers; the port never waits.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit_mode <= 1'b0;
            r_line_width    <= LINE_WIDTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FOUR_BIT_MODE: r_four_bit_mode <= i_cfg_data[0];
                CFG_LINE_WIDTH:    r_line_width    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Line width in use, clamped to one pixel up to the longest line.
    always_comb begin
        s_width = r_line_width;
        if (s_width > LINE_LIMIT) begin
            s_width = LINE_LIMIT;
        end
        if (s_width == '0) begin
            s_width = 13'd1;
        end
    end

    // Stream parser.
    bmprle_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (s_accept),
        .i_byte          (i_stream_byte),
        .i_four_bit_mode (r_four_bit_mode),
        .i_width         (s_width),
        .o_batch         (s_batch)
    );

    // Record buffer.
    bmprle_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_valid),
        .o_item_stall (o_stall),
        .o_accept     (s_accept),
        .i_batch      (s_batch),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rec        (s_rec),
        .o_last       (o_last_of_run)
    );

    // Record fields onto the ports.
    assign o_record_kind  = s_rec.kind;
    assign o_first_index  = s_rec.first_index;
    assign o_second_index = s_rec.second_index;
    assign o_run_count    = s_rec.run_count;
    assign o_start_column = s_rec.start_column;

endmodule

>>> sim/tb_bmp_rle_line_decoder_unit.sv
// Self-checking testbench for the BMP RLE line decoder with its run record scoreboard.
`timescale 1ns / 100ps

package run_record_check_pkg;
    import bmprle_pkg::*;

    // One run record as the decoder should emit it.
    typedef struct {
        t_kind        kind;
        logic [7:0]   first_index;
        logic [7:0]   second_index;
        logic [12:0]  run_count;
        logic [11:0]  start_column;
        logic         last_of_run;
    } t_run_record;

    // Tracks the decoder state, works out the records of each accepted item and
    // checks every emitted record against the oldest one still due.
    class decoded_run_board;
        bit            four_bit;
        int unsigned   width_reg;
        t_phase        phase;
        logic [7:0]    held;
        int unsigned   column;
        int unsigned   abs_left;
        bit            pad_due;
        logic [7:0]    dx;
        bit            stuck;
        t_run_record   records_due[$];
        t_run_record   fresh[$];
        int unsigned   faults;

        function new();
            four_bit  = 1'b0;
            width_reg = LINE_WIDTH_RESET;
            phase     = PH_FIRST;
            held      = '0;
            column    = 0;
            abs_left  = 0;
            pad_due   = 1'b0;
            dx        = '0;
            stuck     = 1'b0;
            faults    = 0;
        endfunction

        // Configured width, clamped to what the decoder supports.
        function int unsigned line_limit();
            int unsigned w;
            w = width_reg;
            if (w > LIMIT_PIXELS) w = LIMIT_PIXELS;
            if (w < 1) w = 1;
            return w;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [12:0] value);
            if (idx == CFG_FOUR_BIT_MODE) four_bit = value[0];
            else if (idx == CFG_LINE_WIDTH) width_reg = value;
        endfunction

        function void emit(t_kind kind, logic [7:0] a, logic [7:0] b, int unsigned cnt,
                           int unsigned col);
            t_run_record r;
            r.kind         = kind;
            r.first_index  = a;
            r.second_index = b;
            r.run_count    = 13'(cnt);
            r.start_column = 12'(col);
            r.last_of_run  = 1'b0;
            fresh.push_back(r);
        endfunction

        // Once set, the error sticks and every later item gives the same record.
        function void raise_error();
            stuck = 1'b1;
            fresh.delete();
            emit(KIND_ERROR, 8'h00, 8'h00, 0, 0);
        endfunction

        function void fill_rest(int unsigned w);
            if (column < w) emit(KIND_FILL, 8'h00, 8'h00, w - column, column);
        endfunction

        // Works out the records caused by one accepted item.
        function void take_byte(logic [7:0] b);
            int unsigned w;
            int unsigned target;
            int unsigned nbytes;
            int unsigned cnt;
            logic [7:0]  hi;
            logic [7:0]  lo;
            w = line_limit();
            fresh.delete();
            if (stuck) begin
                raise_error();
            end else begin
                case (phase)
                    PH_FIRST: begin
                        held  = b;
                        phase = PH_SECOND;
                    end
                    PH_SECOND: begin
                        phase = PH_FIRST;
                        if (held != 8'h00) begin
                            // Encoded pair: one run, alternating nibbles in 4-bit mode.
                            if (column + held > w) begin
                                raise_error();
                            end else begin
                                hi = b;
                                lo = b;
                                if (four_bit) begin
                                    hi = {4'h0, b[7:4]};
                                    lo = {4'h0, b[3:0]};
                                end
                                emit(KIND_RUN, hi, lo, held, column);
                                column += held;
                            end
                        end else if (b == ESC_EOL) begin
                            fill_rest(w);
                            emit(KIND_EOL, 8'h00, 8'h00, 0, 0);
                            column = 0;
                        end else if (b == ESC_EOB) begin
                            fill_rest(w);
                            emit(KIND_EOB, 8'h00, 8'h00, 0, 0);
                            column = 0;
                        end else if (b == ESC_DELTA) begin
                            phase = PH_DX;
                        end else begin
                            // Absolute run; the pad byte is decided here.
                            nbytes = four_bit ? (int'(b) + 1) / 2 : int'(b);
                            if (column + b > w) begin
                                raise_error();
                            end else begin
                                abs_left = b;
                                pad_due  = nbytes[0];
                                phase    = PH_ABS;
                            end
                        end
                    end
                    PH_DX: begin
                        dx    = b;
                        phase = PH_DY;
                    end
                    PH_DY: begin
                        phase = PH_FIRST;
                        if (b == 8'h00) begin
                            if (column + dx > w) begin
                                raise_error();
                            end else begin
                                if (dx != 8'h00) emit(KIND_FILL, 8'h00, 8'h00, dx, column);
                                column += dx;
                            end
                        end else begin
                            target = column + dx;
                            if (target > w) begin
                                raise_error();
                            end else begin
                                fill_rest(w);
                                emit(KIND_BLANK, 8'h00, 8'h00, int'(b) - 1, 0);
                                if (target > 0) emit(KIND_FILL, 8'h00, 8'h00, target, 0);
                                column = target;
                            end
                        end
                    end
                    PH_ABS: begin
                        cnt = 1;
                        hi  = b;
                        lo  = b;
                        if (four_bit) begin
                            hi = {4'h0, b[7:4]};
                            lo = {4'h0, b[3:0]};
                            if (abs_left >= 2) cnt = 2;
                        end
                        if (cnt > abs_left) cnt = abs_left;
                        emit(KIND_RUN, hi, lo, cnt, column);
                        column   += cnt;
                        abs_left -= cnt;
                        if (abs_left == 0) begin
                            phase   = pad_due ? PH_PAD : PH_FIRST;
                            pad_due = 1'b0;
                        end
                    end
                    PH_PAD: begin
                        phase   = PH_FIRST;
                        pad_due = 1'b0;
                    end
                    default: begin
                        phase = PH_FIRST;
                    end
                endcase
            end
            if (fresh.size() != 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
            foreach (fresh[i]) records_due.push_back(fresh[i]);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                faults++;
            end
        endfunction

        // Checks one emitted record against the oldest record still due.
        function void match_record(logic [2:0] kind, logic [7:0] first, logic [7:0] second,
                                   logic [12:0] count, logic [11:0] start_col, logic last);
            t_run_record want;
            if (records_due.size() == 0) begin
                $error("record of kind %0d arrived with none due", kind);
                faults++;
            end else begin
                want = records_due.pop_front();
                compare_field("record_kind", want.kind, kind);
                compare_field("first_index", want.first_index, first);
                compare_field("second_index", want.second_index, second);
                compare_field("run_count", want.run_count, count);
                compare_field("start_column", want.start_column, start_col);
                compare_field("last_of_run", want.last_of_run, last);
            end
        endfunction
    endclass
endpackage

module tb_bmp_rle_line_decoder_unit;
    import bmprle_pkg::*;
    import run_record_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 90;
    localparam int unsigned PHASES        = 7;
    localparam int unsigned PHASE_ITEMS   = 26;

    // Ways of breaking the stream at the end of the run.
    typedef enum int unsigned {
        BREAK_RUN,
        BREAK_ABSOLUTE,
        BREAK_SKIP,
        BREAK_JUMP,
        BREAK_FULL
    } t_break_kind;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_stream_byte  = '0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic [2:0]            o_record_kind;
    logic [BYTE_W-1:0]     o_first_index;
    logic [BYTE_W-1:0]     o_second_index;
    logic [COL_W-1:0]      o_run_count;
    logic [START_W-1:0]    o_start_column;
    logic                  o_last_of_run;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [COL_W-1:0]      i_cfg_data     = '0;

    decoded_run_board      board;
    bit                    calm_mode      = 1'b0;
    int unsigned           bytes_sent     = 0;
    int unsigned           cycle_count    = 0;
    int unsigned           hold_left      = 0;
    int unsigned           hold_asked     = 0;
    int unsigned           hold_taken     = 0;

    bmp_rle_line_decoder_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_stream_byte  (i_stream_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_record_kind  (o_record_kind),
        .o_first_index  (o_first_index),
        .o_second_index (o_second_index),
        .o_run_count    (o_run_count),
        .o_start_column (o_start_column),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1ns i_clk = 1'b1;
        #1ns i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !calm_mode && ($urandom_range(99) < 22);
    endfunction

    // Receiver stalls: random, or a long hold-off when one is asked for.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            i_stall    <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_taken + 1;
        end else begin
            i_stall <= take_gap();
        end
    end

    // Every record taken from the decoder is checked at once.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.match_record(o_record_kind, o_first_index, o_second_index,
                               o_run_count, o_start_column, o_last_of_run);
        end
    end

    // Offers one item, with random gaps before it, and notes it once accepted.
    task automatic send_byte(input logic [7:0] value);
        while (take_gap()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.take_byte(value);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Stops offering items until every record due has arrived and the decoder is quiet.
    task automatic settle();
        i_valid <= 1'b0;
        while (board.records_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COL_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // One well-formed command that keeps within the current line.
    task automatic random_command();
        int unsigned w;
        int unsigned room;
        int unsigned lim;
        int unsigned pick;
        int unsigned n;
        int unsigned nbytes;
        w    = board.line_limit();
        room = (board.column < w) ? w - board.column : 0;
        lim  = (room < 255) ? room : 255;
        pick = $urandom_range(99);
        if (room == 0 || pick < 10) begin
            // Close the line, now and then the whole bitmap.
            send_byte(8'h00);
            send_byte(($urandom_range(7) == 0) ? ESC_EOB : ESC_EOL);
        end else if (pick < 55) begin
            // Encoded pair, mostly short so that lines last a while.
            n = ($urandom_range(3) == 0) ? $urandom_range(lim, 1)
                                         : $urandom_range((lim < 6) ? lim : 6, 1);
            send_byte(8'(n));
            send_byte(8'($urandom));
        end else if (pick < 80 && room >= 3) begin
            // Absolute run, padded to an even number of data bytes.
            n = ($urandom_range(19) == 0) ? $urandom_range(lim, 3)
                                          : $urandom_range((lim < 9) ? lim : 9, 3);
            nbytes = board.four_bit ? (n + 1) / 2 : n;
            send_byte(8'h00);
            send_byte(8'(n));
            repeat (nbytes) send_byte(8'($urandom));
            if (nbytes % 2 == 1) send_byte(8'($urandom));
        end else begin
            // Delta: a skip on this line or a jump down some lines.
            n = ($urandom_range(3) == 0) ? $urandom_range(lim, 0)
                                         : $urandom_range((lim < 5) ? lim : 5, 0);
            send_byte(8'h00);
            send_byte(ESC_DELTA);
            send_byte(8'(n));
            send_byte(($urandom_range(2) == 0) ? 8'($urandom_range(255, 1)) : 8'h00);
        end
    endtask

    // Drives the decoder into its error state from the start of a line, then feeds noise.
    task automatic break_stream();
        int unsigned room;
        t_break_kind how;
        room = board.line_limit() - board.column;
        how  = t_break_kind'($urandom_range(4));
        case (how)
            BREAK_RUN: begin
                send_byte(8'(room + 1));
                send_byte(8'($urandom));
            end
            BREAK_ABSOLUTE: begin
                send_byte(8'h00);
                send_byte(8'(room + 1));
            end
            BREAK_SKIP: begin
                send_byte(8'h00);
                send_byte(ESC_DELTA);
                send_byte(8'(room + 1));
                send_byte(8'h00);
            end
            BREAK_JUMP: begin
                send_byte(8'h00);
                send_byte(ESC_DELTA);
                send_byte(8'(room + 1));
                send_byte(8'($urandom_range(255, 1)));
            end
            default: begin
                // Fill the line exactly, then one pixel too many.
                send_byte(8'(room));
                send_byte(8'($urandom));
                send_byte(8'd1);
                send_byte(8'($urandom));
            end
        endcase
        repeat (6) send_byte(8'($urandom));
    endtask

    initial begin
        logic [7:0]  script[$];
        logic [12:0] width_plan[PHASES];
        int unsigned p;
        int unsigned phase_base;

        board = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // RLE8 at the reset width: longest pair, extreme values, padded absolute run,
        // empty skip, a jump that gives three records, end of bitmap.
        script = '{8'd255, 8'h00, 8'd1, 8'hFF, 8'h00, 8'd3, 8'hA5, 8'h5A, 8'hC3, 8'h77,
                   8'h00, ESC_DELTA, 8'd0, 8'd0, 8'h00, ESC_DELTA, 8'd10, 8'd1,
                   8'h00, ESC_EOB};
        foreach (script[i]) send_byte(script[i]);

        // RLE4 on a narrow line: full line then end of line, the longest blank jump,
        // odd absolute run with its pad, a skip to the end of the line.
        settle();
        write_reg(CFG_FOUR_BIT_MODE, 13'd1);
        write_reg(CFG_LINE_WIDTH, 13'd8);
        script = '{8'd8, 8'h3C, 8'h00, ESC_EOL, 8'h00, ESC_DELTA, 8'd0, 8'd255,
                   8'h00, 8'd5, 8'h12, 8'h34, 8'h5F, 8'hEE, 8'h00, ESC_DELTA, 8'd3, 8'd0,
                   8'h00, ESC_EOL};
        foreach (script[i]) send_byte(script[i]);

        // Random phases, each under its own mode and width, the extremes among them.
        width_plan = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd0, 13'd3, 13'd0};
        width_plan[3] = 13'($urandom_range(700, 16));
        width_plan[6] = 13'($urandom_range(4096, 1));
        for (p = 0; p < PHASES; p++) begin
            settle();
            write_reg(CFG_FOUR_BIT_MODE, {12'($urandom), 1'(p % 2)});
            write_reg(CFG_LINE_WIDTH, width_plan[p]);
            calm_mode = (p == 2);
            if (p == 3) hold_asked++;
            phase_base = bytes_sent;
            while (bytes_sent - phase_base < PHASE_ITEMS) random_command();
            send_byte(8'h00);
            send_byte(ESC_EOL);
        end
        calm_mode = 1'b0;

        // Last phase: a short stream on a modest width, then the sticky error.
        settle();
        write_reg(CFG_FOUR_BIT_MODE, 13'($urandom_range(1)));
        write_reg(CFG_LINE_WIDTH, 13'($urandom_range(200, 20)));
        phase_base = bytes_sent;
        while (bytes_sent - phase_base < 12) random_command();
        send_byte(8'h00);
        send_byte(ESC_EOL);
        break_stream();

        settle();
        if (board.records_due.size() != 0) begin
            $error("%0d records never arrived", board.records_due.size());
            board.faults++;
        end
        if (board.faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/bmprle_pkg.sv
rtl/bmprle_decode.sv
rtl/bmprle_outq.sv
rtl/bmp_rle_line_decoder_unit.sv
sim/tb_bmp_rle_line_decoder_unit.sv
